// ===== rtl/core/mvrca_pkg.sv =====
package mvrca_pkg;

    // tree shape
    localparam int NODES  = 4;
    localparam int NODE_W = 2;

    // blend constants
    localparam int COUNT_SAT         = 20;
    localparam int MAX_UPDATE_FACTOR = 144;
    localparam int PROB_ONE          = 256;
    localparam int PROB_HALF         = 128;
    localparam int PROB_MAX          = 255;

    // measured probability is 0..256, one quotient bit per divider step
    localparam int QUO_W     = 9;
    localparam int DIV_STEPS = 9;
    localparam int STEP_W    = 4;

    typedef enum logic [1:0] {
        OP_ACCUM = 2'd0,
        OP_ADAPT = 2'd1,
        OP_CLEAR = 2'd2,
        OP_LOAD  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_ADP_RD,
        ST_ADP_INIT,
        ST_ADP_DIV,
        ST_ADP_MUL,
        ST_ADP_SUM
    } t_state;

    typedef struct packed {
        logic cap_acc;
        logic cap_adp;
        logic base_wr;
        logic clr;
        logic acc_wr;
        logic adp_init;
        logic div_step;
        logic adp_mul;
        logic adp_emit;
    } t_cmd;

    typedef struct packed {
        logic acc_done;
        logic div_done;
        logic ent_last;
    } t_status;

    // weight 144 * min(count, 20) / 20, as a table
    function automatic logic [7:0] update_factor(input logic [4:0] sat);
        logic [7:0] f;
        begin
            case (sat)
                5'd0:    f = 8'd0;
                5'd1:    f = 8'd7;
                5'd2:    f = 8'd14;
                5'd3:    f = 8'd21;
                5'd4:    f = 8'd28;
                5'd5:    f = 8'd36;
                5'd6:    f = 8'd43;
                5'd7:    f = 8'd50;
                5'd8:    f = 8'd57;
                5'd9:    f = 8'd64;
                5'd10:   f = 8'd72;
                5'd11:   f = 8'd79;
                5'd12:   f = 8'd86;
                5'd13:   f = 8'd93;
                5'd14:   f = 8'd100;
                5'd15:   f = 8'd108;
                5'd16:   f = 8'd115;
                5'd17:   f = 8'd122;
                5'd18:   f = 8'd129;
                5'd19:   f = 8'd136;
                default: f = 8'(MAX_UPDATE_FACTOR);
            endcase
            return f;
        end
    endfunction

endpackage

// ===== rtl/core/mv_ref_count_and_adapt.sv =====
// accumulate runs one read and one write step per visited tree node (one to four nodes); clear and load
// finish in the accepting cycle. adapt runs read, setup, a 9-step divider and 2 blend steps per entry,
// giving 24 results for the default six contexts; the serial divider is the slowest part of each entry
// one transaction at a time: busy stays high until the last result is registered
// results are strobed for one cycle and cannot be stalled
// synchronous active-low reset clears all counts (per-row valid bits), base values stay undefined
module mv_ref_count_and_adapt #(
    parameter int NUM_CONTEXTS = 6,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic       i_bank,
    input  logic [2:0] i_mode,
    input  logic [2:0] i_ctx_zero_node,
    input  logic [2:0] i_ctx_nearest_node,
    input  logic [2:0] i_ctx_near_node,
    input  logic [2:0] i_ctx_new_node,
    input  logic [4:0] i_entry_index,
    input  logic [7:0] i_base_value,
    output logic       o_strobe,
    output logic [2:0] o_context_index,
    output logic [1:0] o_node_index,
    output logic [7:0] o_probability,
    output logic       o_last
);

    // command and status between the sequencer and the datapath
    mvrca_pkg::t_cmd    cmd;
    mvrca_pkg::t_status status;

    // sequencer: decodes the accepted transaction and walks nodes or entries
    mvrca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // datapath: count and base memories, per-row valid bits, divider and blend
    mvrca_datapath #(
        .NUM_CONTEXTS (NUM_CONTEXTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_bank             (i_bank),
        .i_mode             (i_mode),
        .i_ctx_zero_node    (i_ctx_zero_node),
        .i_ctx_nearest_node (i_ctx_nearest_node),
        .i_ctx_near_node    (i_ctx_near_node),
        .i_ctx_new_node     (i_ctx_new_node),
        .i_entry_index      (i_entry_index),
        .i_base_value       (i_base_value),
        .o_context_index    (o_context_index),
        .o_node_index       (o_node_index),
        .o_probability      (o_probability),
        .o_last             (o_last),
        .o_strobe           (o_strobe)
    );

    // results only come out of an adapt walk in progress
    a_strobe_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a running adapt walk");

    // the final result ends the walk
    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("block still busy after the final result");

    // clear and load finish in the accepting cycle
    a_short_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == mvrca_pkg::OP_CLEAR ||
                            i_opcode == mvrca_pkg::OP_LOAD)) |=> !busy)
        else $error("clear or load left the block busy");

    // clamp keeps the probability nonzero
    a_prob_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_probability != 8'd0))
        else $error("emitted probability of zero");

endmodule

// ===== rtl/core/mvrca_ram.sv =====
module mvrca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/mvrca_ctrl.sv =====
module mvrca_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_opcode,
    input  mvrca_pkg::t_status  i_status,
    output logic                o_busy,
    output mvrca_pkg::t_cmd     o_cmd
);

    mvrca_pkg::t_state r_state;
    mvrca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvrca_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            mvrca_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    case (mvrca_pkg::t_opcode'(i_opcode))
                        mvrca_pkg::OP_ACCUM: begin
                            o_cmd.cap_acc = 1'b1;
                            n_state       = mvrca_pkg::ST_ACC_RD;
                        end
                        mvrca_pkg::OP_ADAPT: begin
                            o_cmd.cap_adp = 1'b1;
                            n_state       = mvrca_pkg::ST_ADP_RD;
                        end
                        mvrca_pkg::OP_CLEAR: begin
                            o_cmd.clr = 1'b1;
                        end
                        mvrca_pkg::OP_LOAD: begin
                            o_cmd.base_wr = 1'b1;
                        end
                        default: begin
                            n_state = mvrca_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mvrca_pkg::ST_ACC_RD: begin
                n_state = mvrca_pkg::ST_ACC_WR;
            end
            mvrca_pkg::ST_ACC_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state = i_status.acc_done ? mvrca_pkg::ST_IDLE : mvrca_pkg::ST_ACC_RD;
            end
            mvrca_pkg::ST_ADP_RD: begin
                n_state = mvrca_pkg::ST_ADP_INIT;
            end
            mvrca_pkg::ST_ADP_INIT: begin
                o_cmd.adp_init = 1'b1;
                n_state        = mvrca_pkg::ST_ADP_DIV;
            end
            mvrca_pkg::ST_ADP_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = mvrca_pkg::ST_ADP_MUL;
                end
            end
            mvrca_pkg::ST_ADP_MUL: begin
                o_cmd.adp_mul = 1'b1;
                n_state       = mvrca_pkg::ST_ADP_SUM;
            end
            mvrca_pkg::ST_ADP_SUM: begin
                o_cmd.adp_emit = 1'b1;
                n_state = i_status.ent_last ? mvrca_pkg::ST_IDLE : mvrca_pkg::ST_ADP_RD;
            end
            default: begin
                n_state = mvrca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/mvrca_datapath.sv =====
module mvrca_datapath #(
    parameter int NUM_CONTEXTS = 6,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mvrca_pkg::t_cmd    i_cmd,
    output mvrca_pkg::t_status o_status,
    input  logic               i_bank,
    input  logic [2:0]         i_mode,
    input  logic [2:0]         i_ctx_zero_node,
    input  logic [2:0]         i_ctx_nearest_node,
    input  logic [2:0]         i_ctx_near_node,
    input  logic [2:0]         i_ctx_new_node,
    input  logic [4:0]         i_entry_index,
    input  logic [7:0]         i_base_value,
    output logic [2:0]         o_context_index,
    output logic [1:0]         o_node_index,
    output logic [7:0]         o_probability,
    output logic               o_last,
    output logic               o_strobe
);

    localparam int CTX_W     = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ENT_W     = CTX_W + mvrca_pkg::NODE_W;
    localparam int BANK_ROWS = 1 << ENT_W;
    localparam int ENTRIES   = NUM_CONTEXTS * mvrca_pkg::NODES;
    localparam int SUM_W     = COUNT_WIDTH + 1;
    localparam int REM_W     = COUNT_WIDTH + 2;
    localparam int PROD_W    = 17;
    localparam int QW        = mvrca_pkg::QUO_W;

    // captured item
    logic                             r_adapt;
    logic                             r_bank;
    logic [2:0]                       r_mode;
    logic [2:0]                       r_ctx [mvrca_pkg::NODES];
    logic [mvrca_pkg::NODE_W-1:0]     r_node;
    logic [ENT_W-1:0]                 r_ent;
    logic [1:0][BANK_ROWS-1:0]        r_valid;

    // divider and blend
    logic [REM_W-1:0]                 r_rem;
    logic [SUM_W-1:0]                 r_den;
    logic [QW-1:0]                    r_quo;
    logic [mvrca_pkg::STEP_W-1:0]     r_step;
    logic                             r_zero;
    logic [7:0]                       r_factor;
    logic [7:0]                       r_base;
    logic [PROD_W-1:0]                r_prod;

    // result registers
    logic                             r_strobe;
    logic [7:0]                       r_prob;
    logic [2:0]                       r_ctx_o;
    logic [1:0]                       r_node_o;
    logic                             r_last;

    logic [2:0]                       cur_ctx;
    logic                             ctx_ok;
    logic [ENT_W-1:0]                 acc_ent;
    logic [ENT_W-1:0]                 rd_ent;
    logic                             row_ok;
    logic [2*COUNT_WIDTH-1:0]         cnt_rdata;
    logic [COUNT_WIDTH-1:0]           c0;
    logic [COUNT_WIDTH-1:0]           c1;
    logic [COUNT_WIDTH-1:0]           new_c0;
    logic [COUNT_WIDTH-1:0]           new_c1;
    logic                             take_left;
    logic                             cnt_we;
    logic [SUM_W-1:0]                 count_sum;
    logic [4:0]                       sat;
    logic [7:0]                       base_rdata;
    logic                             base_we;
    logic [REM_W-1:0]                 shifted;
    logic                             fits;
    logic [QW-1:0]                    meas;
    logic [PROD_W-1:0]                meas_term;
    logic [PROD_W-1:0]                blend_sum;
    logic [QW-1:0]                    p9;
    logic [7:0]                       prob;

    // accumulate walks one node per read/write pair
    assign cur_ctx   = r_ctx[r_node];
    assign ctx_ok    = 5'(cur_ctx) < 5'(NUM_CONTEXTS);
    assign acc_ent   = {CTX_W'(cur_ctx), r_node};
    assign rd_ent    = r_adapt ? r_ent : acc_ent;
    assign row_ok    = r_valid[r_bank][rd_ent];
    assign c0        = row_ok ? cnt_rdata[COUNT_WIDTH-1:0] : '0;
    assign c1        = row_ok ? cnt_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH] : '0;
    assign take_left = (r_mode == 3'(r_node));
    assign new_c0    = (take_left && (c0 != '1)) ? c0 + 1'b1 : c0;
    assign new_c1    = (!take_left && (c1 != '1)) ? c1 + 1'b1 : c1;
    assign cnt_we    = i_cmd.acc_wr && ctx_ok;

    assign count_sum = {1'b0, c0} + {1'b0, c1};
    assign sat       = (count_sum > SUM_W'(mvrca_pkg::COUNT_SAT))
                     ? 5'(mvrca_pkg::COUNT_SAT) : count_sum[4:0];

    assign base_we   = i_cmd.base_wr && (7'(i_entry_index) < 7'(ENTRIES));

    // restoring divider, first step compares without a shift
    assign shifted   = (r_step == '0) ? r_rem : {r_rem[REM_W-2:0], 1'b0};
    assign fits      = shifted >= {1'b0, r_den};

    assign meas      = r_zero ? QW'(mvrca_pkg::PROB_HALF) : r_quo;
    assign meas_term = PROD_W'(meas) * PROD_W'(r_factor);
    assign blend_sum = r_prod + meas_term + PROD_W'(mvrca_pkg::PROB_HALF);
    assign p9        = blend_sum[PROD_W-1:8];
    assign prob      = (p9 == '0) ? 8'd1
                     : (p9 > QW'(mvrca_pkg::PROB_MAX)) ? 8'(mvrca_pkg::PROB_MAX)
                     : p9[7:0];

    assign o_status.acc_done = take_left || (r_node == mvrca_pkg::NODE_W'(mvrca_pkg::NODES - 1));
    assign o_status.div_done = (r_step == mvrca_pkg::STEP_W'(mvrca_pkg::DIV_STEPS - 1));
    assign o_status.ent_last = (r_ent == ENT_W'(ENTRIES - 1));

    mvrca_ram #(
        .WIDTH (2 * COUNT_WIDTH),
        .DEPTH (2 * BANK_ROWS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr ({r_bank, acc_ent}),
        .i_wdata ({new_c1, new_c0}),
        .i_raddr ({r_bank, rd_ent}),
        .o_rdata (cnt_rdata)
    );

    mvrca_ram #(
        .WIDTH (8),
        .DEPTH (BANK_ROWS)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (base_we),
        .i_waddr (ENT_W'(i_entry_index)),
        .i_wdata (i_base_value),
        .i_raddr (r_ent),
        .o_rdata (base_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_adapt  <= 1'b0;
            r_node   <= '0;
            r_ent    <= '0;
            r_step   <= '0;
        end else begin
            r_strobe <= i_cmd.adp_emit;
            if (i_cmd.cap_acc || i_cmd.cap_adp) begin
                r_adapt <= i_cmd.cap_adp;
                r_node  <= '0;
                r_ent   <= '0;
            end
            if (i_cmd.clr) begin
                r_valid[i_bank] <= '0;
            end
            if (cnt_we) begin
                r_valid[r_bank][acc_ent] <= 1'b1;
            end
            if (i_cmd.acc_wr) begin
                r_node <= r_node + 1'b1;
            end
            if (i_cmd.adp_init) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.adp_emit) begin
                r_ent <= r_ent + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_acc || i_cmd.cap_adp) begin
            r_bank   <= i_bank;
            r_mode   <= i_mode;
            r_ctx[0] <= i_ctx_zero_node;
            r_ctx[1] <= i_ctx_nearest_node;
            r_ctx[2] <= i_ctx_near_node;
            r_ctx[3] <= i_ctx_new_node;
        end
        if (i_cmd.adp_init) begin
            r_rem    <= REM_W'(c0);
            r_den    <= count_sum;
            r_quo    <= '0;
            r_zero   <= (count_sum == '0);
            r_factor <= mvrca_pkg::update_factor(sat);
            r_base   <= base_rdata;
        end
        if (i_cmd.div_step) begin
            r_rem <= fits ? shifted - {1'b0, r_den} : shifted;
            r_quo <= {r_quo[QW-2:0], fits};
        end
        if (i_cmd.adp_mul) begin
            r_prod <= PROD_W'(r_base)
                    * (PROD_W'(mvrca_pkg::PROB_ONE) - PROD_W'(r_factor));
        end
        if (i_cmd.adp_emit) begin
            r_prob   <= prob;
            r_ctx_o  <= 3'(r_ent[ENT_W-1:mvrca_pkg::NODE_W]);
            r_node_o <= r_ent[mvrca_pkg::NODE_W-1:0];
            r_last   <= o_status.ent_last;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_probability   = r_prob;
    assign o_context_index = r_ctx_o;
    assign o_node_index    = r_node_o;
    assign o_last          = r_last;

endmodule

// ===== tb/mvrca_checker.sv =====
`timescale 1ns / 100ps

module mvrca_checker
    import mvrca_pkg::*;
#(
    parameter int NUM_CONTEXTS = 6,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [1:0] i_opcode,
    input  logic       i_bank,
    input  logic [2:0] i_mode,
    input  logic [2:0] i_ctx_zero_node,
    input  logic [2:0] i_ctx_nearest_node,
    input  logic [2:0] i_ctx_near_node,
    input  logic [2:0] i_ctx_new_node,
    input  logic [4:0] i_entry_index,
    input  logic [7:0] i_base_value,
    input  logic       i_strobe,
    input  logic [2:0] i_context_index,
    input  logic [1:0] i_node_index,
    input  logic [7:0] i_probability,
    input  logic       i_last,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_results_seen
);

    localparam int ENTRIES     = NUM_CONTEXTS * NODES;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [2:0] ctx;
        logic [1:0] node;
        logic [7:0] prob;
        logic       last;
    } t_prob_result;

    logic [COUNT_WIDTH-1:0] tally [2][NUM_CONTEXTS][NODES][2];
    logic [7:0]             base_tbl [ENTRIES];
    t_prob_result           prob_expect_q [$];
    int                     mismatch_cnt = 0;
    int                     seen_cnt     = 0;

    // count-weighted mix of base and measured left-branch probability
    function automatic logic [7:0] blend_left_prob(input logic [7:0] base,
                                                   input logic [COUNT_WIDTH-1:0] n_left,
                                                   input logic [COUNT_WIDTH-1:0] n_right);
        longint unsigned left, total, measured, sat, weight, mix;
        left     = n_left;
        total    = left + n_right;
        measured = PROB_HALF;
        if (total != 0)
            measured = (PROB_ONE * left) / total;
        sat    = (total > COUNT_SAT) ? COUNT_SAT : total;
        weight = (MAX_UPDATE_FACTOR * sat) / COUNT_SAT;
        mix    = (base * (PROB_ONE - weight) + measured * weight + PROB_HALF) >> 8;
        if (mix == 0)
            return 8'd1;
        if (mix > PROB_MAX)
            return 8'(PROB_MAX);
        return 8'(mix);
    endfunction

    task automatic bump_branch(input logic bank, input logic [2:0] ctx,
                               input int node, input int branch);
        if (ctx < NUM_CONTEXTS && tally[bank][ctx][node][branch] != '1)
            tally[bank][ctx][node][branch] = tally[bank][ctx][node][branch] + 1'b1;
    endtask

    task automatic clear_bank(input logic bank);
        for (int c = 0; c < NUM_CONTEXTS; c++)
            for (int n = 0; n < NODES; n++) begin
                tally[bank][c][n][0] = '0;
                tally[bank][c][n][1] = '0;
            end
    endtask

    task automatic apply_transaction();
        logic [2:0]   node_ctx [NODES];
        logic         walked;
        t_prob_result r;
        node_ctx[0] = i_ctx_zero_node;
        node_ctx[1] = i_ctx_nearest_node;
        node_ctx[2] = i_ctx_near_node;
        node_ctx[3] = i_ctx_new_node;
        walked      = 1'b0;
        case (t_opcode'(i_opcode))
            OP_ACCUM: begin
                // node k: left for mode k, right for anything above; 5..7 act as split
                for (int n = 0; n < NODES; n++) begin
                    if (!walked) begin
                        if (i_mode == n) begin
                            bump_branch(i_bank, node_ctx[n], n, 0);
                            walked = 1'b1;
                        end else begin
                            bump_branch(i_bank, node_ctx[n], n, 1);
                        end
                    end
                end
            end
            OP_ADAPT: begin
                for (int c = 0; c < NUM_CONTEXTS; c++)
                    for (int n = 0; n < NODES; n++) begin
                        r.ctx  = 3'(c);
                        r.node = 2'(n);
                        r.prob = blend_left_prob(base_tbl[c * NODES + n],
                                                 tally[i_bank][c][n][0],
                                                 tally[i_bank][c][n][1]);
                        r.last = (c * NODES + n == ENTRIES - 1);
                        prob_expect_q.push_back(r);
                    end
            end
            OP_CLEAR: clear_bank(i_bank);
            OP_LOAD: begin
                if (i_entry_index < ENTRIES)
                    base_tbl[i_entry_index] = i_base_value;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_prob_result got, want;
        if (!i_rst_n) begin
            clear_bank(1'b0);
            clear_bank(1'b1);
            prob_expect_q.delete();
        end else begin
            // results are checked before a transaction taken on the same edge
            if (i_strobe) begin
                got = '{i_context_index, i_node_index, i_probability, i_last};
                seen_cnt++;
                if (prob_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result ctx %0d node %0d prob %0d last %0d",
                                 $time, got.ctx, got.node, got.prob, got.last);
                end else begin
                    want = prob_expect_q.pop_front();
                    if (got.ctx !== want.ctx || got.node !== want.node ||
                        got.prob !== want.prob || got.last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display("%0t: expected ctx %0d node %0d prob %0d last %0d",
                                     $time, want.ctx, want.node, want.prob, want.last);
                            $display("%0t: got      ctx %0d node %0d prob %0d last %0d",
                                     $time, got.ctx, got.node, got.prob, got.last);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                apply_transaction();
        end
        o_mismatches   <= mismatch_cnt;
        o_pending      <= prob_expect_q.size();
        o_results_seen <= seen_cnt;
    end

endmodule

// ===== tb/tb_mv_ref_count_and_adapt.sv =====
`timescale 1ns / 100ps

module tb_mv_ref_count_and_adapt;
    import mvrca_pkg::*;

    localparam int CTX_COUNT    = 6;
    localparam int CNT_W        = 16;
    localparam int N_ENTRIES    = CTX_COUNT * NODES;
    localparam int CLAMP_HITS   = 22;
    localparam int RANDOM_ITEMS = 360;
    localparam int CALM_FROM    = 240;     // last stretch of the random part runs gap-free
    localparam int IDLE_PCT     = 19;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 1000;

    // mode tree codes
    localparam logic [2:0] MODE_ZERO    = 3'd0;
    localparam logic [2:0] MODE_NEAREST = 3'd1;
    localparam logic [2:0] MODE_NEAR    = 3'd2;
    localparam logic [2:0] MODE_NEW     = 3'd3;
    localparam logic [2:0] MODE_SPLIT   = 3'd4;

    localparam logic BANK_NORMAL = 1'b0;
    localparam logic BANK_ALTREF = 1'b1;

    typedef struct packed {
        t_opcode    op;
        logic       bank;
        logic [2:0] mode;
        logic [2:0] ctx_zero;
        logic [2:0] ctx_nearest;
        logic [2:0] ctx_near;
        logic [2:0] ctx_new;
        logic [4:0] entry;
        logic [7:0] value;
    } t_mv_xact;

    logic       i_clk;
    logic       i_rst_n            = 1'b0;
    logic       start              = 1'b0;
    logic       busy;
    logic [1:0] i_opcode           = OP_ACCUM;
    logic       i_bank             = 1'b0;
    logic [2:0] i_mode             = '0;
    logic [2:0] i_ctx_zero_node    = '0;
    logic [2:0] i_ctx_nearest_node = '0;
    logic [2:0] i_ctx_near_node    = '0;
    logic [2:0] i_ctx_new_node     = '0;
    logic [4:0] i_entry_index      = '0;
    logic [7:0] i_base_value       = '0;
    logic       o_strobe;
    logic [2:0] o_context_index;
    logic [1:0] o_node_index;
    logic [7:0] o_probability;
    logic       o_last;

    int mismatches;
    int pending;
    int results_seen;

    // sender gaps on or off
    logic idle_on = 1'b1;
    int   n_acc   = 0;
    int   n_adapt = 0;
    int   n_clear = 0;
    int   n_load  = 0;
    int   quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    mv_ref_count_and_adapt #(
        .NUM_CONTEXTS(CTX_COUNT),
        .COUNT_WIDTH (CNT_W)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_bank            (i_bank),
        .i_mode            (i_mode),
        .i_ctx_zero_node   (i_ctx_zero_node),
        .i_ctx_nearest_node(i_ctx_nearest_node),
        .i_ctx_near_node   (i_ctx_near_node),
        .i_ctx_new_node    (i_ctx_new_node),
        .i_entry_index     (i_entry_index),
        .i_base_value      (i_base_value),
        .o_strobe          (o_strobe),
        .o_context_index   (o_context_index),
        .o_node_index      (o_node_index),
        .o_probability     (o_probability),
        .o_last            (o_last)
    );

    mvrca_checker #(
        .NUM_CONTEXTS(CTX_COUNT),
        .COUNT_WIDTH (CNT_W)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .i_busy            (busy),
        .i_opcode          (i_opcode),
        .i_bank            (i_bank),
        .i_mode            (i_mode),
        .i_ctx_zero_node   (i_ctx_zero_node),
        .i_ctx_nearest_node(i_ctx_nearest_node),
        .i_ctx_near_node   (i_ctx_near_node),
        .i_ctx_new_node    (i_ctx_new_node),
        .i_entry_index     (i_entry_index),
        .i_base_value      (i_base_value),
        .i_strobe          (o_strobe),
        .i_context_index   (o_context_index),
        .i_node_index      (o_node_index),
        .i_probability     (o_probability),
        .i_last            (o_last),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_results_seen    (results_seen)
    );

    // watchdog: a stretch with no transaction and no result means a hang
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly in-range contexts, now and then one the block must skip
    function automatic logic [2:0] pick_ctx();
        if ($urandom_range(99) < 90)
            return 3'($urandom_range(CTX_COUNT - 1));
        return 3'($urandom_range(7, CTX_COUNT));
    endfunction

    // fields an opcode does not use still carry random bits
    function automatic t_mv_xact noise_xact(input t_opcode op);
        t_mv_xact    x;
        logic [31:0] raw;
        raw  = $urandom;
        x    = raw[$bits(t_mv_xact)-1:0];
        x.op = op;
        return x;
    endfunction

    function automatic t_mv_xact mk_acc(input logic b, input logic [2:0] m,
                                        input logic [2:0] cz, input logic [2:0] cn,
                                        input logic [2:0] cr, input logic [2:0] cw);
        t_mv_xact x;
        x             = noise_xact(OP_ACCUM);
        x.bank        = b;
        x.mode        = m;
        x.ctx_zero    = cz;
        x.ctx_nearest = cn;
        x.ctx_near    = cr;
        x.ctx_new     = cw;
        return x;
    endfunction

    function automatic t_mv_xact mk_bank_op(input t_opcode op, input logic b);
        t_mv_xact x;
        x      = noise_xact(op);
        x.bank = b;
        return x;
    endfunction

    function automatic t_mv_xact mk_load(input logic [4:0] e, input logic [7:0] v);
        t_mv_xact x;
        x       = noise_xact(OP_LOAD);
        x.entry = e;
        x.value = v;
        return x;
    endfunction

    // one transaction: optional gap, then hold start until busy drops at an edge
    task automatic drive(input t_mv_xact x);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge i_clk);
        end
        start              <= 1'b1;
        i_opcode           <= x.op;
        i_bank             <= x.bank;
        i_mode             <= x.mode;
        i_ctx_zero_node    <= x.ctx_zero;
        i_ctx_nearest_node <= x.ctx_nearest;
        i_ctx_near_node    <= x.ctx_near;
        i_ctx_new_node     <= x.ctx_new;
        i_entry_index      <= x.entry;
        i_base_value       <= x.value;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        case (x.op)
            OP_ACCUM: n_acc++;
            OP_ADAPT: n_adapt++;
            OP_CLEAR: n_clear++;
            default:  n_load++;
        endcase
    endtask

    // sender holds off until every adapted probability is back
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    function automatic t_mv_xact random_xact();
        int r;
        r = $urandom_range(99);
        if (r < 72)
            return mk_acc(1'($urandom_range(1)),
                          ($urandom_range(99) < 90) ? 3'($urandom_range(4))
                                                    : 3'($urandom_range(7)),
                          pick_ctx(), pick_ctx(), pick_ctx(), pick_ctx());
        if (r < 78)
            return mk_bank_op(OP_ADAPT, 1'($urandom_range(1)));
        if (r < 82)
            return mk_bank_op(OP_CLEAR, 1'($urandom_range(1)));
        return mk_load(($urandom_range(99) < 90) ? 5'($urandom_range(N_ENTRIES - 1))
                                                 : 5'($urandom_range(31, N_ENTRIES)),
                       8'($urandom_range(255)));
    endfunction

    initial begin
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every base slot gets a value before any adapt; slot 0 at zero, slot 1 at full
        for (k = 0; k < N_ENTRIES; k++)
            drive(mk_load(5'(k), (k == 0) ? 8'd0 :
                                 (k == 1) ? 8'd255 : 8'($urandom_range(255))));

        // no counts yet: base passes straight through, zero base clamps up to one
        drive(mk_bank_op(OP_ADAPT, BANK_NORMAL));

        // every mode, including the codes above split, with skipped contexts mixed in
        drive(mk_acc(BANK_NORMAL, MODE_ZERO,    3'd0, 3'd0, 3'd0, 3'd0));
        drive(mk_acc(BANK_NORMAL, MODE_NEAREST, 3'd5, 3'd5, 3'd5, 3'd5));
        drive(mk_acc(BANK_NORMAL, MODE_NEAR,    3'd1, 3'd2, 3'd3, 3'd4));
        drive(mk_acc(BANK_NORMAL, MODE_NEW,     3'd2, 3'd3, 3'd4, 3'd5));
        drive(mk_acc(BANK_NORMAL, MODE_SPLIT,   3'd3, 3'd3, 3'd3, 3'd3));
        drive(mk_acc(BANK_NORMAL, MODE_SPLIT + 3'd1, 3'd4, 3'd4, 3'd4, 3'd4));
        drive(mk_acc(BANK_NORMAL, MODE_SPLIT + 3'd3, 3'd6, 3'd7, 3'd0, 3'd1));
        drive(mk_acc(BANK_ALTREF, MODE_SPLIT + 3'd2, 3'd7, 3'd6, 3'd7, 3'd6));
        drive(mk_acc(BANK_ALTREF, MODE_NEAREST, 3'd0, 3'd0, 3'd0, 3'd0));

        // out-of-range slots are dropped, the top slot is not
        drive(mk_load(5'd24, 8'h5A));
        drive(mk_load(5'd31, 8'hFF));
        drive(mk_load(5'(N_ENTRIES - 1), 8'd1));

        drive(mk_bank_op(OP_ADAPT, BANK_NORMAL));
        drive(mk_bank_op(OP_ADAPT, BANK_ALTREF));
        drain_results();

        // clearing one bank leaves the other alone
        drive(mk_bank_op(OP_CLEAR, BANK_NORMAL));
        drive(mk_bank_op(OP_ADAPT, BANK_NORMAL));
        drive(mk_bank_op(OP_ADAPT, BANK_ALTREF));
        drive(mk_bank_op(OP_CLEAR, BANK_ALTREF));

        // both clamps run on the alternate bank, no gaps to keep it short
        idle_on = 1'b0;
        drive(mk_load(5'd4, 8'd255));
        for (k = 8; k < 12; k++)
            drive(mk_load(5'(k), 8'd0));
        // full base with all-left counts rounds past 255, zero base with all-right to zero
        for (k = 0; k < CLAMP_HITS; k++)
            drive(mk_acc(BANK_ALTREF, MODE_ZERO, 3'd1, pick_ctx(), pick_ctx(), pick_ctx()));
        for (k = 0; k < CLAMP_HITS; k++)
            drive(mk_acc(BANK_ALTREF, MODE_SPLIT, 3'd2, 3'd2, 3'd2, 3'd2));
        drive(mk_bank_op(OP_ADAPT, BANK_ALTREF));

        // random traffic, with a gap-free tail and the odd full drain
        idle_on = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == CALM_FROM)
                idle_on = 1'b0;
            if ($urandom_range(99) < 2)
                drain_results();
            drive(random_xact());
        end

        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d accumulate, %0d adapt, %0d clear and %0d load transactions",
                 n_acc, n_adapt, n_clear, n_load);
        $display("checked %0d adapted probabilities incl. both clamps and skipped contexts",
                 results_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
